// ----- hw/rtl/i2c_tcr_pkg.sv -----
// ----------------------------------------------------------------------------
// I2C target command responder package
// Shared beat types, command and result codes, and sizing constants.
// ----------------------------------------------------------------------------
package i2c_tcr_pkg;

  localparam int unsigned NUM_ENCODERS_DEF = 7;
  localparam int unsigned NUM_KNOBS_DEF    = 3;
  localparam int unsigned NUM_BUTTONS_DEF  = 6;
  localparam int unsigned NUM_TAPES_DEF    = 6;

  localparam int unsigned BUF_DEPTH = 9;
  localparam int unsigned BUF_IDX_W = 4;

  // input command codes
  typedef enum logic [2:0] {
    CMD_WRITE  = 3'd0,
    CMD_READ   = 3'd1,
    CMD_STOP   = 3'd2,
    CMD_ENC    = 3'd3,
    CMD_KNOB   = 3'd4,
    CMD_BUTTON = 3'd5
  } cmd_e;

  // result kinds
  typedef enum logic [2:0] {
    KIND_READ = 3'd0,
    KIND_TAPE = 3'd1,
    KIND_LOOP = 3'd2,
    KIND_DONE = 3'd3,
    KIND_NOTE = 3'd4
  } kind_e;

  // first buffer byte selects the operation
  localparam logic [7:0] OP_ENCODERS = 8'h01;
  localparam logic [7:0] OP_KNOBS    = 8'h02;
  localparam logic [7:0] OP_BUTTONS  = 8'h03;
  localparam logic [7:0] OP_TAPE     = 8'h04;
  localparam logic [7:0] OP_LOOP     = 8'h05;
  localparam logic [7:0] OP_DONE     = 8'h06;
  localparam logic [7:0] OP_NOTE     = 8'h07;

  typedef enum logic {
    ST_IDLE,
    ST_EMIT
  } state_e;

  typedef struct packed {
    logic [2:0]         command;
    logic [7:0]         data_byte;
    logic [2:0]         channel;
    logic signed [15:0] sample_value;
  } in_beat_t;

  typedef struct packed {
    logic [2:0] kind;
    logic [7:0] value;
    logic       last;
    logic [2:0] tape_index;
    logic [7:0] tape_phase;
    logic [7:0] tape_phase_last;
    logic [7:0] tape_phase_rec;
    logic [7:0] tape_pan;
    logic [7:0] tape_amp;
    logic [7:0] tape_fade;
    logic [6:0] tape_flags;
  } out_beat_t;

  // controller -> datapath
  typedef struct packed {
    logic apply;      // input beat accepted, update state
    logic load;       // load output register with result at index
    logic last;       // result being loaded is the final one
    logic is_stop;    // result comes from stop handling
    logic clr_fresh;  // read finished (clears the fresh flags after a knob read)
  } dp_cmd_t;

  // datapath -> controller
  typedef struct packed {
    logic out_free;   // output register can take a beat this cycle
    logic stop_hit;   // stop produces one result
  } dp_stat_t;

endpackage

// ----- hw/rtl/i2c_tcr_datapath.sv -----
// ----------------------------------------------------------------------------
// I2C target command responder datapath
// Command buffer, sensor state, result selection and output register.
// ----------------------------------------------------------------------------
module i2c_tcr_datapath import i2c_tcr_pkg::*; #(
  parameter int unsigned NumEncoders = NUM_ENCODERS_DEF,
  parameter int unsigned NumKnobs    = NUM_KNOBS_DEF,
  parameter int unsigned NumButtons  = NUM_BUTTONS_DEF,
  parameter int unsigned NumTapes    = NUM_TAPES_DEF,
  parameter int unsigned CntW        = 6
) (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  in_beat_t        in_data_i,
  input  dp_cmd_t         cmd_i,
  input  logic [CntW-1:0] idx_i,
  output dp_stat_t        stat_o,
  output logic [CntW-1:0] read_cnt_o,
  input  logic            out_stall_i,
  output logic            out_valid_o,
  output out_beat_t       out_data_o
);

  localparam int unsigned EncW = (NumEncoders > 1) ? $clog2(NumEncoders) : 1;
  localparam int unsigned KnW  = (NumKnobs > 1) ? $clog2(NumKnobs) : 1;
  localparam int unsigned BtnW = (NumButtons > 1) ? $clog2(NumButtons) : 1;

  logic [7:0]          buf_q [BUF_DEPTH];
  logic [7:0]          wp_q;
  logic                open_q;
  logic [15:0]         enc_q [NumEncoders];
  logic [14:0]         knob_q [NumKnobs];
  logic [NumKnobs-1:0] fresh_q;
  logic [NumButtons-1:0] btn_q;
  logic                out_valid_q;
  out_beat_t           out_q;

  logic [7:0]  wp_eff;
  logic [EncW-1:0] enc_sel;
  logic [KnW-1:0]  knob_sel;
  logic [BtnW-1:0] btn_sel;
  out_beat_t   res;

  assign wp_eff   = open_q ? wp_q : 8'd0;
  assign enc_sel  = idx_i[EncW:1];
  assign knob_sel = idx_i[KnW:1];
  assign btn_sel  = idx_i[BtnW-1:0];

  always_comb begin
    case (buf_q[0])
      OP_ENCODERS: read_cnt_o = CntW'(2 * NumEncoders);
      OP_KNOBS:    read_cnt_o = CntW'(2 * NumKnobs);
      OP_BUTTONS:  read_cnt_o = CntW'(NumButtons);
      default:     read_cnt_o = '0;
    endcase
  end

  always_comb begin
    stat_o.out_free = !out_valid_q || !out_stall_i;
    case (buf_q[0])
      OP_TAPE:                   stat_o.stop_hit = 32'(buf_q[1]) < NumTapes;
      OP_LOOP, OP_DONE, OP_NOTE: stat_o.stop_hit = 1'b1;
      default:                   stat_o.stop_hit = 1'b0;
    endcase
  end

  // result for the current index
  always_comb begin
    res      = '0;
    res.last = cmd_i.last;
    if (!cmd_i.is_stop) begin
      res.kind = KIND_READ;
      case (buf_q[0])
        OP_ENCODERS: res.value = idx_i[0] ? enc_q[enc_sel][7:0] : enc_q[enc_sel][15:8];
        OP_KNOBS:    res.value = idx_i[0] ? knob_q[knob_sel][7:0]
                                          : {fresh_q[knob_sel], knob_q[knob_sel][14:8]};
        OP_BUTTONS:  res.value = {7'd0, btn_q[btn_sel]};
        default:     res.value = '0;
      endcase
    end else begin
      case (buf_q[0])
        OP_TAPE: begin
          res.kind            = KIND_TAPE;
          res.tape_index      = buf_q[1][2:0];
          res.tape_phase      = buf_q[2];
          res.tape_phase_last = buf_q[3];
          res.tape_phase_rec  = buf_q[4];
          res.tape_pan        = buf_q[5];
          res.tape_amp        = buf_q[6];
          res.tape_fade       = buf_q[7];
          res.tape_flags      = buf_q[8][6:0];
        end
        OP_LOOP: begin
          res.kind  = KIND_LOOP;
          res.value = buf_q[1];
        end
        OP_DONE: res.kind = KIND_DONE;
        OP_NOTE: begin
          res.kind  = KIND_NOTE;
          res.value = buf_q[1];
        end
        default: res.kind = KIND_READ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < BUF_DEPTH; i++) buf_q[i] <= '0;
      for (int i = 0; i < NumEncoders; i++) enc_q[i] <= '0;
      for (int i = 0; i < NumKnobs; i++) knob_q[i] <= '0;
      wp_q    <= '0;
      open_q  <= 1'b0;
      fresh_q <= '0;
      btn_q   <= '0;
    end else begin
      if (cmd_i.apply) begin
        case (cmd_e'(in_data_i.command))
          CMD_WRITE: begin
            if (32'(wp_eff) < BUF_DEPTH) buf_q[wp_eff[BUF_IDX_W-1:0]] <= in_data_i.data_byte;
            wp_q   <= wp_eff + 8'd1;
            open_q <= 1'b1;
          end
          CMD_READ, CMD_STOP: open_q <= 1'b0;
          CMD_ENC: begin
            if (32'(in_data_i.channel) < NumEncoders)
              enc_q[EncW'(in_data_i.channel)] <= in_data_i.sample_value;
          end
          CMD_KNOB: begin
            if (32'(in_data_i.channel) < NumKnobs) begin
              knob_q[KnW'(in_data_i.channel)]  <= in_data_i.sample_value[14:0];
              fresh_q[KnW'(in_data_i.channel)] <= 1'b1;
            end
          end
          CMD_BUTTON: begin
            if (32'(in_data_i.channel) < NumButtons)
              btn_q[BtnW'(in_data_i.channel)] <= in_data_i.sample_value[0];
          end
          default: ;
        endcase
      end
      if (cmd_i.clr_fresh && buf_q[0] == OP_KNOBS) fresh_q <= '0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (cmd_i.load) begin
      out_valid_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) out_q <= res;
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

endmodule

// ----- hw/rtl/i2c_tcr_ctrl.sv -----
// ----------------------------------------------------------------------------
// I2C target command responder controller
// Accepts beats and sequences result emission for read and stop commands.
// ----------------------------------------------------------------------------
module i2c_tcr_ctrl import i2c_tcr_pkg::*; #(
  parameter int unsigned CntW = 6
) (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            in_valid_i,
  input  logic [2:0]      in_command_i,
  output logic            in_stall_o,
  input  dp_stat_t        stat_i,
  input  logic [CntW-1:0] read_cnt_i,
  output dp_cmd_t         cmd_o,
  output logic [CntW-1:0] idx_o
);

  state_e          state_q, state_d;
  logic [CntW-1:0] idx_q, idx_d;
  logic [CntW-1:0] cnt_q, cnt_d;
  logic            stop_q, stop_d;
  logic            accept;

  assign accept     = in_valid_i && (state_q == ST_IDLE);
  assign in_stall_o = (state_q != ST_IDLE);
  assign idx_o      = idx_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      idx_q   <= '0;
      cnt_q   <= '0;
      stop_q  <= 1'b0;
    end else begin
      state_q <= state_d;
      idx_q   <= idx_d;
      cnt_q   <= cnt_d;
      stop_q  <= stop_d;
    end
  end

  always_comb begin
    state_d         = state_q;
    idx_d           = idx_q;
    cnt_d           = cnt_q;
    stop_d          = stop_q;
    cmd_o           = '0;
    cmd_o.apply     = accept;
    cmd_o.is_stop   = stop_q;
    case (state_q)
      ST_IDLE: begin
        idx_d = '0;
        if (accept) begin
          if (cmd_e'(in_command_i) == CMD_READ && read_cnt_i != '0) begin
            state_d = ST_EMIT;
            cnt_d   = read_cnt_i;
            stop_d  = 1'b0;
          end else if (cmd_e'(in_command_i) == CMD_STOP && stat_i.stop_hit) begin
            state_d = ST_EMIT;
            cnt_d   = CntW'(1);
            stop_d  = 1'b1;
          end
        end
      end
      ST_EMIT: begin
        if (stat_i.out_free) begin
          cmd_o.load = 1'b1;
          cmd_o.last = (idx_q == cnt_q - CntW'(1));
          if (cmd_o.last) begin
            state_d         = ST_IDLE;
            cmd_o.clr_fresh = !stop_q;
          end else begin
            idx_d = idx_q + CntW'(1);
          end
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

endmodule

// ----- hw/rtl/i2c_target_command_responder_top.sv -----
// ----------------------------------------------------------------------------
// I2C target command responder
// Register-style I2C target front end: command buffer and sensor readback.
// ----------------------------------------------------------------------------
// Input channel (in_valid_i / in_stall_o / in_data_i) carries bus write bytes,
// read requests, stop/restart events and sensor updates. Output channel
// (out_valid_o / out_stall_i / out_data_o) carries read bytes and stop results;
// out_data_o.last flags the final beat caused by one input beat.
// Writes, sensor updates and commands with no result do not stall, and the
// next beat is taken in the following cycle.
// A read request or stop with results holds in_stall_o high while its results
// are loaded into the output register one per cycle while that register is free
// (up to the largest of 2*NumEncoders, 2*NumKnobs and NumButtons, 14 by default).
// The result sequencer is gated only by the single output register, so a
// stalled receiver freezes emission; the last result may still wait in that
// register while the next input beat is accepted.
// Reset clears the command buffer, write pointer, transfer flag, all sensor
// state and the output valid.
// ----------------------------------------------------------------------------
module i2c_target_command_responder_top import i2c_tcr_pkg::*; #(
  parameter int unsigned NumEncoders = NUM_ENCODERS_DEF,
  parameter int unsigned NumKnobs    = NUM_KNOBS_DEF,
  parameter int unsigned NumButtons  = NUM_BUTTONS_DEF,
  parameter int unsigned NumTapes    = NUM_TAPES_DEF
) (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      in_valid_i,
  output logic      in_stall_o,
  input  in_beat_t  in_data_i,
  output logic      out_valid_o,
  input  logic      out_stall_i,
  output out_beat_t out_data_o
);

  localparam int unsigned MaxA   = (NumEncoders > NumKnobs) ? 2 * NumEncoders : 2 * NumKnobs;
  localparam int unsigned MaxRes = (MaxA > NumButtons) ? MaxA : NumButtons;
  localparam int unsigned CntW   = $clog2(MaxRes + 1);

  dp_cmd_t         dp_cmd;
  dp_stat_t        dp_stat;
  logic [CntW-1:0] idx;
  logic [CntW-1:0] read_cnt;

  i2c_tcr_ctrl #(
    .CntW (CntW)
  ) u_ctrl (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (in_valid_i),
    .in_command_i (in_data_i.command),
    .in_stall_o   (in_stall_o),
    .stat_i       (dp_stat),
    .read_cnt_i   (read_cnt),
    .cmd_o        (dp_cmd),
    .idx_o        (idx)
  );

  i2c_tcr_datapath #(
    .NumEncoders (NumEncoders),
    .NumKnobs    (NumKnobs),
    .NumButtons  (NumButtons),
    .NumTapes    (NumTapes),
    .CntW        (CntW)
  ) u_dp (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_data_i   (in_data_i),
    .cmd_i       (dp_cmd),
    .idx_i       (idx),
    .stat_o      (dp_stat),
    .read_cnt_o  (read_cnt),
    .out_stall_i (out_stall_i),
    .out_valid_o (out_valid_o),
    .out_data_o  (out_data_o)
  );

endmodule

// ----- hw/rtl/i2c_tcr_checker.sv -----
// ----------------------------------------------------------------------------
// I2C target command responder checker
// Port-level properties of the responder, bound to the top level.
// ----------------------------------------------------------------------------
module i2c_tcr_checker import i2c_tcr_pkg::*; (
  input logic      clk_i,
  input logic      rst_ni,
  input logic      in_valid_i,
  input logic      in_stall_o,
  input in_beat_t  in_data_i,
  input logic      out_valid_o,
  input logic      out_stall_i,
  input out_beat_t out_data_o
);

  // a stalled output beat holds
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o && $stable(out_data_o))
    else $error("stalled output beat changed");

  // beats that produce no result never block the next one
  a_no_block: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && !in_stall_o && in_data_i.command != CMD_READ
      && in_data_i.command != CMD_STOP |=> !in_stall_o)
    else $error("input stalled after a beat with no results");

  // stop results are single beats
  a_stop_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_data_o.kind != KIND_READ |-> out_data_o.last)
    else $error("stop result without last");

  // emission ends with the last beat presented
  a_end_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $fell(in_stall_o) |-> out_valid_o && out_data_o.last)
    else $error("input released without final result");

endmodule

bind i2c_target_command_responder_top i2c_tcr_checker u_i2c_tcr_checker (.*);
